// ----- rtl/pdd_pkg.sv -----
// Package for the Pelco-D drive command decoder.
// Holds frame constants, config/frame structs and the motor speed table.
// No dependencies.
package pdd_pkg;

  // Frame layout
  localparam logic [7:0] SYNC_BYTE     = 8'hFF;
  localparam int         DATA_LEN      = 5;
  localparam int         POS_W         = 3;
  localparam int         IDX_W         = $clog2(DATA_LEN);
  localparam logic [POS_W-1:0] POS_WAIT = 3'd0;
  localparam logic [POS_W-1:0] POS_CKS  = 3'd6;

  // Command codes
  localparam logic [7:0] CMD1_CAM_ON   = 8'h88;
  localparam logic [7:0] CMD1_CAM_OFF  = 8'h08;
  localparam logic [7:0] DATA1_CAMERA  = 8'h01;
  localparam logic [7:0] SPEED_SEL_MIN = 8'd1;
  localparam logic [7:0] SPEED_SEL_MAX = 8'd9;

  // Field widths
  localparam int DUTY_W  = 15;
  localparam int SPEED_W = 10;

  // Register reset values
  localparam logic [7:0]        ADDR_RST   = 8'd1;
  localparam logic [DUTY_W-1:0] CENTER_RST = 15'd1700;
  localparam logic [DUTY_W-1:0] LEFT_RST   = 15'd1300;
  localparam logic [DUTY_W-1:0] RIGHT_RST  = 15'd2000;

  // APB register map
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_ADDRESS = 2'd0;
  localparam logic [1:0] REG_CENTER  = 2'd1;
  localparam logic [1:0] REG_LEFT    = 2'd2;
  localparam logic [1:0] REG_RIGHT   = 2'd3;

  typedef struct packed {
    logic [7:0]        device_address;
    logic [DUTY_W-1:0] servo_center_duty;
    logic [DUTY_W-1:0] servo_left_duty;
    logic [DUTY_W-1:0] servo_right_duty;
  } cfg_t;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] cmd1;
    logic [7:0] cmd2;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [7:0] sum;
  } frame_t;

  // Motor duty for speed select 1..9, zero otherwise
  function automatic logic [SPEED_W-1:0] speed_lookup(input logic [7:0] sel);
    logic [SPEED_W-1:0] r;
    case (sel)
      8'd1:    r = 10'd150;
      8'd2:    r = 10'd200;
      8'd3:    r = 10'd250;
      8'd4:    r = 10'd300;
      8'd5:    r = 10'd350;
      8'd6:    r = 10'd400;
      8'd7:    r = 10'd450;
      8'd8:    r = 10'd500;
      8'd9:    r = 10'd800;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/pdd_cfg.sv -----
// APB configuration registers of the Pelco-D decoder.
// Depends on pdd_pkg for the register map and cfg_t.
module pdd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdd_pkg::PADDR_W-1:0] paddr,
  input  logic [pdd_pkg::PDATA_W-1:0] pwdata,
  output logic [pdd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output pdd_pkg::cfg_t               cfg
);
  import pdd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Write the selected register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address    <= ADDR_RST;
      cfg.servo_center_duty <= CENTER_RST;
      cfg.servo_left_duty   <= LEFT_RST;
      cfg.servo_right_duty  <= RIGHT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ADDRESS: cfg.device_address    <= pwdata[7:0];
        REG_CENTER:  cfg.servo_center_duty <= pwdata[DUTY_W-1:0];
        REG_LEFT:    cfg.servo_left_duty   <= pwdata[DUTY_W-1:0];
        REG_RIGHT:   cfg.servo_right_duty  <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_ADDRESS: prdata = {{(PDATA_W-8){1'b0}}, cfg.device_address};
      REG_CENTER:  prdata = {{(PDATA_W-DUTY_W){1'b0}}, cfg.servo_center_duty};
      REG_LEFT:    prdata = {{(PDATA_W-DUTY_W){1'b0}}, cfg.servo_left_duty};
      REG_RIGHT:   prdata = {{(PDATA_W-DUTY_W){1'b0}}, cfg.servo_right_duty};
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- rtl/pdd_framer.sv -----
// Byte framer: tracks position in a 7-byte frame, captures the five body
// bytes and the running checksum. Depends on pdd_pkg.
module pdd_framer (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output logic            at_checksum,
  output pdd_pkg::frame_t frame
);
  import pdd_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;
  logic [7:0]       frame_bytes [DATA_LEN];
  logic             in_body;
  logic [POS_W-1:0] wr_pos;

  assign at_checksum = (byte_position == POS_CKS);
  assign in_body     = (byte_position != POS_WAIT) && (byte_position < POS_CKS);
  assign wr_pos      = byte_position - POS_W'(1);

  // Position and checksum sequencing
  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    if (in_body) begin
      byte_position_next = byte_position + POS_W'(1);
      running_sum_next   = running_sum + rx_byte;
    end else if (at_checksum) begin
      byte_position_next = POS_WAIT;
      running_sum_next   = '0;
    end else if (rx_byte == SYNC_BYTE) begin
      byte_position_next = POS_W'(1);
      running_sum_next   = '0;
    end else begin
      byte_position_next = POS_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_WAIT;
      running_sum   <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
    end
  end

  // Capture body bytes
  always_ff @(posedge clk) begin
    if (accept && in_body) begin
      frame_bytes[wr_pos[IDX_W-1:0]] <= rx_byte;
    end
  end

  assign frame.address = frame_bytes[0];
  assign frame.cmd1    = frame_bytes[1];
  assign frame.cmd2    = frame_bytes[2];
  assign frame.data1   = frame_bytes[3];
  assign frame.data2   = frame_bytes[4];
  assign frame.sum     = running_sum;

endmodule

// ----- rtl/pdd_drive.sv -----
// Command decode, drive state and result register of the Pelco-D decoder.
// Depends on pdd_pkg for frame_t, cfg_t and the speed table.
module pdd_drive (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [7:0]                  rx_byte,
  input  pdd_pkg::frame_t             frame,
  input  pdd_pkg::cfg_t               cfg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pdd_pkg::DUTY_W-1:0]  servo_duty,
  output logic [pdd_pkg::SPEED_W-1:0] motor_speed,
  output logic                        motor_forward,
  output logic                        motor_backward,
  output logic                        camera_on,
  output logic                        camera_off,
  output logic                        checksum_error
);
  import pdd_pkg::*;

  logic [DUTY_W-1:0]  servo_duty_reg, servo_duty_next;
  logic [SPEED_W-1:0] motor_speed_reg, motor_speed_next;
  logic               forward_pin, forward_pin_next;
  logic               backward_pin, backward_pin_next;
  logic               cks_ok, addr_match, cam_on_req, cam_off_req, apply;
  logic               speed_sel_ok;

  // Frame qualification
  assign cks_ok       = (rx_byte == frame.sum);
  assign addr_match   = (frame.address == cfg.device_address) && !frame.cmd2[0];
  assign cam_on_req   = (frame.cmd1 == CMD1_CAM_ON) && (frame.data1 == DATA1_CAMERA);
  assign cam_off_req  = (frame.cmd1 == CMD1_CAM_OFF) && (frame.data1 == DATA1_CAMERA);
  assign apply        = cks_ok && addr_match && !cam_on_req && !cam_off_req;
  assign speed_sel_ok = (frame.data2 >= SPEED_SEL_MIN) && (frame.data2 <= SPEED_SEL_MAX);

  // Drive decode
  always_comb begin
    servo_duty_next   = servo_duty_reg;
    motor_speed_next  = motor_speed_reg;
    forward_pin_next  = forward_pin;
    backward_pin_next = backward_pin;
    if (apply) begin
      if (frame.cmd2[1]) begin
        servo_duty_next = cfg.servo_right_duty;
      end else if (frame.cmd2[2]) begin
        servo_duty_next = cfg.servo_left_duty;
      end else begin
        servo_duty_next = cfg.servo_center_duty;
      end
      if (frame.cmd2[3] || frame.cmd2[4]) begin
        if (speed_sel_ok) begin
          motor_speed_next  = speed_lookup(frame.data2);
          forward_pin_next  = frame.cmd2[3];
          backward_pin_next = !frame.cmd2[3];
        end
      end else begin
        motor_speed_next  = '0;
        forward_pin_next  = 1'b0;
        backward_pin_next = 1'b0;
      end
    end
  end

  // Drive state
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_duty_reg  <= CENTER_RST;
      motor_speed_reg <= '0;
      forward_pin     <= 1'b0;
      backward_pin    <= 1'b0;
    end else if (fire) begin
      servo_duty_reg  <= servo_duty_next;
      motor_speed_reg <= motor_speed_next;
      forward_pin     <= forward_pin_next;
      backward_pin    <= backward_pin_next;
    end
  end

  // Result valid: set on a finished frame, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      servo_duty     <= servo_duty_next;
      motor_speed    <= motor_speed_next;
      motor_forward  <= forward_pin_next;
      motor_backward <= backward_pin_next;
      camera_on      <= cks_ok && addr_match && cam_on_req;
      camera_off     <= cks_ok && addr_match && !cam_on_req && cam_off_req;
      checksum_error <= !cks_ok;
    end
  end

  a_cam_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(camera_on && camera_off))
    else $error("both camera flags set in one result");

  a_cks_no_cam: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_error |-> !camera_on && !camera_off)
    else $error("camera flag on a frame with bad checksum");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(motor_forward && motor_backward))
    else $error("both direction pins driven");

  a_stopped_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !motor_forward && !motor_backward |-> motor_speed == '0)
    else $error("nonzero motor speed with no direction");

endmodule

// ----- rtl/pelco_d_drive_command_decoder.sv -----
// Pelco-D drive command decoder: frames a byte stream and drives servo/motor.
// One byte is accepted per cycle unless stalled; a result appears in the
// cycle after the checksum byte is accepted (at most one result per 7 bytes).
// Input stalls only on a checksum byte while a previous result is still held.
// Synchronous reset restores register defaults, centers the servo, stops the
// motor and returns the framer to waiting for sync.
module pelco_d_drive_command_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pdd_pkg::DUTY_W-1:0]  servo_duty,
  output logic [pdd_pkg::SPEED_W-1:0] motor_speed,
  output logic                        motor_forward,
  output logic                        motor_backward,
  output logic                        camera_on,
  output logic                        camera_off,
  output logic                        checksum_error,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdd_pkg::PADDR_W-1:0] paddr,
  input  logic [pdd_pkg::PDATA_W-1:0] pwdata,
  output logic [pdd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pdd_pkg::*;

  cfg_t   cfg;
  frame_t frame;
  logic   at_checksum;
  logic   accept;
  logic   fire;

  // Hold a checksum byte while the result register is still occupied
  assign in_stall = at_checksum && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign fire     = accept && at_checksum;

  pdd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdd_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .at_checksum (at_checksum),
    .frame       (frame)
  );

  pdd_drive u_drive (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .rx_byte        (rx_byte),
    .frame          (frame),
    .cfg            (cfg),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .servo_duty     (servo_duty),
    .motor_speed    (motor_speed),
    .motor_forward  (motor_forward),
    .motor_backward (motor_backward),
    .camera_on      (camera_on),
    .camera_off     (camera_off),
    .checksum_error (checksum_error)
  );

endmodule
